// ===== hw/rtl/toa_pkg.sv =====
// ----------------------------------------------------------------------------
// toa_pkg
// Shared types and constants of the timestamp offset adder pipeline.
// ----------------------------------------------------------------------------
package toa_pkg;

	// timestamp field widths
	localparam int unsigned SecW  = 32;
	localparam int unsigned CycW  = 27;
	localparam int unsigned FracW = 12;
	localparam int unsigned OffW  = 32;

	// offset magnitude split: 8000 ps = 2^6 * 125
	localparam int unsigned LoW   = 6;
	localparam int unsigned XW    = OffW - LoW;
	localparam int unsigned DcW   = 19;
	localparam int unsigned RemW  = 13;
	localparam int unsigned TW    = RemW + LoW;

	// reciprocal of 125 scaled by 2^32, truncated
	localparam int unsigned RecipW = 26;
	localparam logic [RecipW-1:0] RECIP_125 = 26'd34359738;
	localparam int unsigned RecipShift = 32;
	localparam logic [7:0] DIV_125 = 8'd125;

	// 8 ns cycles per second
	localparam logic [CycW-1:0] CYCLES_PER_SEC = 27'd125000000;

	// seconds adjust codes
	typedef enum logic [1:0] {
		SEC_KEEP = 2'd0,
		SEC_INC  = 2'd1,
		SEC_DEC  = 2'd2
	} toa_sec_op_t;

	// full timestamp
	typedef struct packed {
		logic [SecW-1:0]  sec_hi;
		logic [SecW-1:0]  sec_lo;
		logic [CycW-1:0]  cyc;
		logic [FracW-1:0] frac;
	} toa_time_t;

	// offset decomposed into cycles and fraction
	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [DcW-1:0]   dc;
		logic [FracW-1:0] df;
	} toa_delta_t;

endpackage

// ===== hw/rtl/timestamp_offset_adder_unit.sv =====
// ----------------------------------------------------------------------------
// timestamp_offset_adder_unit
// Applies a signed picosecond offset to a seconds / 8 ns cycles / fraction
// timestamp.
//
// Input channel: in_valid / in_stall with the timestamp words and offset_ps.
// Output channel: out_valid / out_stall with the adjusted timestamp.
// A word moves at a clock edge where valid is high and stall is low.
// Five stages split the offset into cycles and fraction (two reciprocal
// multiplies by 1/125, each followed by a correction stage), three stages
// apply fraction, cycle count and the 64-bit seconds carry.
// Throughput is one word per cycle while the receiver does not stall. A
// stall from the receiver holds the output register; empty stages behind it
// keep filling, so in_stall rises only once every stage holds a word.
// Nothing is dropped or duplicated.
// Reset clears all valid bits; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module timestamp_offset_adder_unit import toa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SecW-1:0]        seconds_high,
	input  logic [SecW-1:0]        seconds_low,
	input  logic [CycW-1:0]        cycles_in,
	input  logic [FracW-1:0]       fraction_in,
	input  logic signed [OffW-1:0] offset_ps,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SecW-1:0]        seconds_high_out,
	output logic [SecW-1:0]        seconds_low_out,
	output logic [CycW-1:0]        cycles_out,
	output logic [FracW-1:0]       fraction_out
);

	toa_time_t  in_time;
	toa_time_t  mid_time;
	toa_delta_t mid_delta;
	toa_time_t  res_time;
	logic       mid_valid;
	logic       mid_stall;

	// input word packing
	assign in_time.sec_hi = seconds_high;
	assign in_time.sec_lo = seconds_low;
	assign in_time.cyc    = cycles_in;
	assign in_time.frac   = fraction_in;

	// offset decomposition
	toa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_time   (in_time),
		.in_offset (offset_ps),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.out_time  (mid_time),
		.out_delta (mid_delta)
	);

	// carry chain through fraction, cycles, seconds
	toa_apply u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.in_time   (mid_time),
		.in_delta  (mid_delta),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_time  (res_time)
	);

	assign seconds_high_out = res_time.sec_hi;
	assign seconds_low_out  = res_time.sec_lo;
	assign cycles_out       = res_time.cyc;
	assign fraction_out     = res_time.frac;

endmodule

// ===== hw/rtl/toa_div.sv =====
// ----------------------------------------------------------------------------
// toa_div
// Five-stage split of the offset magnitude into whole 8 ns cycles and a
// fraction in 1/4096 units, using reciprocal multiplies with one correction.
// ----------------------------------------------------------------------------
module toa_div import toa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  toa_time_t              in_time,
	input  logic signed [OffW-1:0] in_offset,
	output logic                   out_valid,
	input  logic                   out_stall,
	output toa_time_t              out_time,
	output toa_delta_t             out_delta
);

	// stage registers
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	toa_time_t        t_s1, t_s2, t_s3, t_s4, t_s5;
	logic             neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic             zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic [XW-1:0]    x_s1, x_s2;
	logic [LoW-1:0]   lo_s1, lo_s2;
	logic [DcW-1:0]   q_s2;
	logic [DcW-1:0]   dc_s3, dc_s4, dc_s5;
	logic [RemW-1:0]  rem_s3;
	logic [TW-1:0]    tv_s4;
	logic [FracW-1:0] dfq_s4;
	logic [FracW-1:0] df_s5;

	logic en1, en2, en3, en4, en5;

	// stage advance chain, bubbles collapse
	assign en5 = !v_s5 || !out_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	// stage 1: magnitude of the offset
	logic [OffW-1:0] off_u;
	logic [OffW-1:0] mag;
	always_comb begin
		off_u = OffW'(in_offset);
		mag   = off_u[OffW-1] ? (~off_u + OffW'(1)) : off_u;
	end

	// stage 2: quotient estimate of (mag / 64) / 125
	logic [XW+RecipW-1:0] prod1;
	assign prod1 = (XW+RecipW)'(x_s1) * (XW+RecipW)'(RECIP_125);

	// stage 3: correct the quotient, form the remainder in ps
	logic [XW-1:0] r1_full;
	logic [7:0]    r1;
	logic [DcW-1:0] dc_c;
	logic [6:0]    r1_c;
	always_comb begin
		r1_full = x_s2 - XW'(XW'(q_s2) * XW'(DIV_125));
		r1      = r1_full[7:0];
		if (r1 >= DIV_125) begin
			dc_c = q_s2 + DcW'(1);
			r1_c = 7'(r1 - DIV_125);
		end else begin
			dc_c = q_s2;
			r1_c = r1[6:0];
		end
	end

	// stage 4: fraction estimate of (rem * 64) / 125
	logic [TW-1:0]          tv;
	logic [TW+RecipW-1:0]   prod2;
	always_comb begin
		tv    = {rem_s3, {LoW{1'b0}}};
		prod2 = (TW+RecipW)'(tv) * (TW+RecipW)'(RECIP_125);
	end

	// stage 5: correct the fraction
	logic [TW-1:0] r2_full;
	logic [FracW-1:0] df_c;
	always_comb begin
		r2_full = tv_s4 - TW'(TW'(dfq_s4) * TW'(DIV_125));
		df_c    = (r2_full[7:0] >= DIV_125) ? (dfq_s4 + FracW'(1)) : dfq_s4;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1    <= in_time;
			neg_s1  <= off_u[OffW-1];
			zero_s1 <= (off_u == '0);
			x_s1    <= mag[OffW-1:LoW];
			lo_s1   <= mag[LoW-1:0];
		end
		if (en2) begin
			t_s2    <= t_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			x_s2    <= x_s1;
			lo_s2   <= lo_s1;
			q_s2    <= prod1[RecipShift+DcW-1:RecipShift];
		end
		if (en3) begin
			t_s3    <= t_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			dc_s3   <= dc_c;
			rem_s3  <= {r1_c, lo_s2};
		end
		if (en4) begin
			t_s4    <= t_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			dc_s4   <= dc_s3;
			tv_s4   <= tv;
			dfq_s4  <= prod2[RecipShift+FracW-1:RecipShift];
		end
		if (en5) begin
			t_s5    <= t_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			dc_s5   <= dc_s4;
			df_s5   <= df_c;
		end
	end

	assign out_valid       = v_s5;
	assign out_time        = t_s5;
	assign out_delta.neg   = neg_s5;
	assign out_delta.zero  = zero_s5;
	assign out_delta.dc    = dc_s5;
	assign out_delta.df    = df_s5;

endmodule

// ===== hw/rtl/toa_apply.sv =====
// ----------------------------------------------------------------------------
// toa_apply
// Three-stage add or subtract of the decomposed offset: fraction, then
// cycle count with wrap at one second, then the 64-bit seconds count.
// ----------------------------------------------------------------------------
module toa_apply import toa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  toa_time_t  in_time,
	input  toa_delta_t in_delta,
	output logic       out_valid,
	input  logic       out_stall,
	output toa_time_t  out_time
);

	logic              v_s6, v_s7, v_s8;
	toa_time_t         t_s6, t_s7, t_s8;
	logic              neg_s6, zero_s6;
	logic [DcW:0]      dc_s6;
	toa_sec_op_t       sop_s7;

	logic en6, en7, en8;

	// stage advance chain
	assign en8 = !v_s8 || !out_stall;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign in_stall = !en6;

	// stage 6: fraction with carry or borrow into the cycle delta
	logic [FracW:0] fr_res;
	logic [DcW:0]   dc_adj;
	always_comb begin
		if (in_delta.neg) begin
			fr_res = {1'b0, in_time.frac} - {1'b0, in_delta.df};
		end else begin
			fr_res = {1'b0, in_time.frac} + {1'b0, in_delta.df};
		end
		dc_adj = (DcW+1)'(in_delta.dc) + (DcW+1)'(fr_res[FracW]);
	end

	// stage 7: cycle count with wrap at one second
	logic [CycW:0]    cy_sum;
	logic [CycW-1:0]  cy_res;
	toa_sec_op_t      sop;
	always_comb begin
		cy_sum = {1'b0, t_s6.cyc} + (CycW+1)'(dc_s6);
		cy_res = t_s6.cyc;
		sop    = SEC_KEEP;
		if (zero_s6) begin
			cy_res = t_s6.cyc;
			sop    = SEC_KEEP;
		end else if (!neg_s6) begin
			if (cy_sum >= {1'b0, CYCLES_PER_SEC}) begin
				cy_res = CycW'(cy_sum - {1'b0, CYCLES_PER_SEC});
				sop    = SEC_INC;
			end else begin
				cy_res = cy_sum[CycW-1:0];
			end
		end else begin
			if (t_s6.cyc >= CycW'(dc_s6)) begin
				cy_res = t_s6.cyc - CycW'(dc_s6);
			end else begin
				cy_res = t_s6.cyc + CYCLES_PER_SEC - CycW'(dc_s6);
				sop    = SEC_DEC;
			end
		end
	end

	// stage 8: seconds increment or decrement, wraps at 2^64
	logic [2*SecW-1:0] secs;
	logic [2*SecW-1:0] secs_res;
	always_comb begin
		secs = {t_s7.sec_hi, t_s7.sec_lo};
		case (sop_s7)
			SEC_INC: secs_res = secs + (2*SecW)'(1);
			SEC_DEC: secs_res = secs - (2*SecW)'(1);
			default: secs_res = secs;
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en6) v_s6 <= in_valid;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en6) begin
			t_s6         <= {in_time.sec_hi, in_time.sec_lo, in_time.cyc,
				fr_res[FracW-1:0]};
			neg_s6       <= in_delta.neg;
			zero_s6      <= in_delta.zero;
			dc_s6        <= dc_adj;
		end
		if (en7) begin
			t_s7         <= {t_s6.sec_hi, t_s6.sec_lo, cy_res, t_s6.frac};
			sop_s7       <= sop;
		end
		if (en8) begin
			t_s8         <= {secs_res, t_s7.cyc, t_s7.frac};
		end
	end

	assign out_valid = v_s8;
	assign out_time  = t_s8;

endmodule
